// ----- design/qau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, constants and term tables of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int FRAC_BITS = 16;

  localparam int ACC_W  = 68;
  localparam int DIV_W  = 66;
  localparam int DEN_W  = 33;
  localparam int REM_W  = 37;
  localparam int CNT7_W = 7;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ROOT_STEPS = DIV_W / 2;
  localparam int DIV_STEPS  = DIV_W;

  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_CONJ = 3'd1;
  localparam logic [2:0] OP_NORM = 3'd2;
  localparam logic [2:0] OP_INV  = 3'd3;
  localparam logic [2:0] OP_ROT  = 3'd4;
  localparam logic [2:0] OP_MAT  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 1;
  localparam logic [31:0] Q_ONE = 32'd1 << FRAC_BITS;

  typedef logic [3:0][31:0] quad_t;

  typedef struct packed {
    logic [2:0] op;
    quad_t      a;
    quad_t      b;
  } item_t;

  typedef enum logic [2:0] {SRC_A, SRC_B, SRC_V, SRC_T, SRC_C} src_t;

  typedef struct packed {
    src_t       psel;
    logic [1:0] pc;
    src_t       qsel;
    logic [1:0] qc;
    logic       neg;
    logic       raw;
  } term_t;

  typedef struct packed {
    logic             start;
    logic             is_root;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } dreq_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] res;
  } dresp_t;

  function automatic logic [32:0] sat32(logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < SAT_MIN) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] neg32(logic [31:0] v);
    if (v == 32'h80000000) begin
      return {1'b1, 32'h7fffffff};
    end
    return {1'b0, -v};
  endfunction

  // Hamilton product term k of component comp: {p index, q index, negate}.
  function automatic logic [4:0] ham_term(logic [1:0] comp, logic [1:0] k);
    logic [4:0] t;
    case ({comp, k})
      4'h0: t = {2'd1, 2'd2, 1'b0};
      4'h1: t = {2'd2, 2'd1, 1'b1};
      4'h2: t = {2'd0, 2'd3, 1'b0};
      4'h3: t = {2'd3, 2'd0, 1'b0};
      4'h4: t = {2'd2, 2'd0, 1'b0};
      4'h5: t = {2'd0, 2'd2, 1'b1};
      4'h6: t = {2'd1, 2'd3, 1'b0};
      4'h7: t = {2'd3, 2'd1, 1'b0};
      4'h8: t = {2'd0, 2'd1, 1'b0};
      4'h9: t = {2'd1, 2'd0, 1'b1};
      4'ha: t = {2'd2, 2'd3, 1'b0};
      4'hb: t = {2'd3, 2'd2, 1'b0};
      4'hc: t = {2'd3, 2'd3, 1'b0};
      4'hd: t = {2'd0, 2'd0, 1'b1};
      4'he: t = {2'd1, 2'd1, 1'b1};
      default: t = {2'd2, 2'd2, 1'b1};
    endcase
    return t;
  endfunction

  // Rotation matrix entry g (row major), term k. Off-diagonal products are
  // taken twice so that every entry is a sum of four rounded products.
  function automatic logic [4:0] mat_term(logic [3:0] g, logic [1:0] k);
    logic       diag;
    logic [1:0] r;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] m;
    logic       s;
    logic [1:0] c;
    diag = 1'b0;
    r = 2'd0;
    i = 2'd0;
    j = 2'd1;
    m = 2'd2;
    s = 1'b0;
    case (g)
      4'd0: begin diag = 1'b1; r = 2'd0; end
      4'd1: begin i = 2'd0; j = 2'd1; m = 2'd2; s = 1'b0; end
      4'd2: begin i = 2'd0; j = 2'd2; m = 2'd1; s = 1'b1; end
      4'd3: begin i = 2'd0; j = 2'd1; m = 2'd2; s = 1'b1; end
      4'd4: begin diag = 1'b1; r = 2'd1; end
      4'd5: begin i = 2'd1; j = 2'd2; m = 2'd0; s = 1'b0; end
      4'd6: begin i = 2'd0; j = 2'd2; m = 2'd1; s = 1'b0; end
      4'd7: begin i = 2'd1; j = 2'd2; m = 2'd0; s = 1'b1; end
      default: begin diag = 1'b1; r = 2'd2; end
    endcase
    c = k - 2'd1;
    if (diag) begin
      if (k == 2'd0) begin
        return {2'd3, 2'd3, 1'b0};
      end
      return {c, c, (c != r)};
    end
    if (k < 2'd2) begin
      return {i, j, 1'b0};
    end
    return {2'd3, m, s};
  endfunction

  function automatic term_t qau_term(logic [2:0] op, logic [5:0] idx);
    term_t      t;
    logic [4:0] e;
    t.psel = SRC_A;
    t.qsel = SRC_B;
    t.neg  = 1'b0;
    t.raw  = 1'b0;
    t.pc   = idx[1:0];
    t.qc   = idx[1:0];
    case (op)
      OP_MUL: begin
        e = ham_term(idx[3:2], idx[1:0]);
        {t.pc, t.qc, t.neg} = e;
      end
      OP_ROT: begin
        e = ham_term(idx[3:2], idx[1:0]);
        {t.pc, t.qc, t.neg} = e;
        t.psel = idx[4] ? SRC_T : SRC_B;
        t.qsel = idx[4] ? SRC_C : SRC_V;
      end
      OP_MAT: begin
        e = mat_term(idx[5:2], idx[1:0]);
        {t.pc, t.qc, t.neg} = e;
        t.psel = SRC_B;
      end
      default: begin
        t.qsel = SRC_A;
        t.raw  = 1'b1;
      end
    endcase
    return t;
  endfunction

  function automatic logic [5:0] prog_len(logic [2:0] op);
    case (op)
      OP_MUL:  return 6'd16;
      OP_ROT:  return 6'd32;
      OP_MAT:  return 6'd36;
      default: return 6'd4;
    endcase
  endfunction

endpackage

// ----- design/qau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_front
// Command intake: drops unused op codes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module qau_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_op,
  input  qau_pkg::quad_t in_a,
  input  qau_pkg::quad_t in_b,
  input  logic          pop,
  output logic          head_valid,
  output qau_pkg::item_t head
);
  import qau_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              do_pop;

  assign busy       = (count_r == QCNT_W'(QDEPTH));
  assign push       = start && !busy && (in_op <= OP_MAT);
  assign head_valid = (count_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{op: in_op, a: in_a, b: in_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ----- design/qau_divroot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_divroot
// Shared iterative unit: restoring division one bit per cycle, or integer
// square root two radicand bits per cycle.
// ----------------------------------------------------------------------------
module qau_divroot (
  input  logic           clk,
  input  logic           rst_n,
  input  qau_pkg::dreq_t req,
  output qau_pkg::dresp_t resp
);
  import qau_pkg::*;

  logic              run_r;
  logic              done_r;
  logic              is_root_r;
  logic [CNT7_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  work_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [REM_W-1:0]  rem_s;
  logic [REM_W-1:0]  trial;
  logic              take;

  always_comb begin
    if (is_root_r) begin
      rem_s = {rem_r[REM_W-3:0], work_r[DIV_W-1:DIV_W-2]};
      trial = {quo_r[REM_W-3:0], 2'b01};
    end else begin
      rem_s = {rem_r[REM_W-2:0], work_r[DIV_W-1]};
      trial = REM_W'(den_r);
    end
    take = (rem_s >= trial);
  end

  assign resp.done = done_r;
  assign resp.res  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r     <= 1'b1;
        is_root_r <= req.is_root;
        cnt_r     <= req.is_root ? CNT7_W'(ROOT_STEPS) : CNT7_W'(DIV_STEPS);
        rem_r     <= '0;
        work_r    <= req.num;
        quo_r     <= '0;
        den_r     <= req.den;
      end else if (run_r) begin
        rem_r  <= take ? rem_s - trial : rem_s;
        quo_r  <= {quo_r[DIV_W-2:0], take};
        work_r <= is_root_r ? {work_r[DIV_W-3:0], 2'b00} : {work_r[DIV_W-2:0], 1'b0};
        cnt_r  <= cnt_r - CNT7_W'(1);
        if (cnt_r == CNT7_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/qau_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_back
// Execution engine: conjugate, a multiply-accumulate sequencer for products
// and matrix rows, and length, divide and output control for normalize and inverse.
// ----------------------------------------------------------------------------
module qau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  qau_pkg::item_t head,
  output logic           pop,
  output qau_pkg::dreq_t dreq,
  input  qau_pkg::dresp_t dresp,
  output logic           out_valid,
  output qau_pkg::quad_t out_r,
  output logic [1:0]     out_row_index,
  output logic           out_last,
  output logic [1:0]     out_status
);
  import qau_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_ROOT, S_DIV} state_t;

  state_t                  state_r;
  logic [2:0]              op_r;
  quad_t                   a_r;
  quad_t                   b_r;
  quad_t                   bc_r;
  quad_t                   tq_r;
  quad_t                   res_r;
  logic                    flag_r;
  logic                    rflag_r;
  logic [5:0]              iss_r;
  logic [5:0]              len_r;
  logic                    tv_r;
  logic                    tneg_r;
  logic                    traw_r;
  logic                    tfirst_r;
  logic                    tlast_r;
  logic                    tfinal_r;
  logic [3:0]              tgrp_r;
  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [1:0]              col_r;
  logic [1:0]              row_r;
  logic [DEN_W-1:0]        lval_r;
  logic [1:0]              comp_r;
  logic                    pass_r;
  logic                    sgn_r;
  dreq_t                   dreq_r;

  logic                    ov_r;
  quad_t                   or_r;
  logic [1:0]              orow_r;
  logic                    olast_r;
  logic [1:0]              ost_r;

  term_t                   term;
  logic [31:0]             pv;
  logic [31:0]             qv;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] tfull;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] rterm;
  logic signed [ACC_W-1:0] sum;
  logic [32:0]             sres;
  logic [32:0]             cj0;
  logic [32:0]             cj1;
  logic [32:0]             cj2;
  logic [32:0]             bn0;
  logic [32:0]             bn1;
  logic [32:0]             bn2;
  logic signed [ACC_W-1:0] qs;
  logic signed [ACC_W-1:0] sv;
  logic signed [ACC_W-1:0] vfin;
  logic [32:0]             dres;
  logic [DEN_W-1:0]        lnew;

  function automatic logic [31:0] pick(src_t s, logic [1:0] c, quad_t a, quad_t b,
                                       quad_t t, quad_t cb);
    case (s)
      SRC_A:   return a[c];
      SRC_B:   return b[c];
      SRC_V:   return (c == 2'd3) ? 32'd0 : a[c];
      SRC_T:   return t[c];
      default: return cb[c];
    endcase
  endfunction

  function automatic logic [DIV_W-1:0] num_of(logic [31:0] v, logic [DEN_W-1:0] l);
    logic [32:0] ext;
    logic [32:0] mag;
    ext = {v[31], v};
    mag = v[31] ? (~ext + 33'd1) : ext;
    return (DIV_W'(mag) << FRAC_BITS) + DIV_W'(l >> 1);
  endfunction

  always_comb begin
    term  = qau_term(op_r, iss_r);
    pv    = pick(term.psel, term.pc, a_r, b_r, tq_r, bc_r);
    qv    = pick(term.qsel, term.qc, a_r, b_r, tq_r, bc_r);
    prod  = $signed(pv) * $signed(qv);
    tfull = ACC_W'(prod_r);
    rnd   = tfull + ACC_HALF;
    rterm = traw_r ? tfull : (rnd >>> FRAC_BITS);
    sum   = (tfirst_r ? '0 : acc_r) + (tneg_r ? -rterm : rterm);
    sres  = sat32(sum);
    cj0   = neg32(head.a[0]);
    cj1   = neg32(head.a[1]);
    cj2   = neg32(head.a[2]);
    bn0   = neg32(head.b[0]);
    bn1   = neg32(head.b[1]);
    bn2   = neg32(head.b[2]);
    qs    = {{(ACC_W-DIV_W){1'b0}}, dresp.res};
    sv    = sgn_r ? -qs : qs;
    vfin  = ((op_r == OP_INV) && (comp_r != 2'd3)) ? -sv : sv;
    dres  = sat32(vfin);
    lnew  = dresp.res[DEN_W-1:0];
  end

  assign pop           = (state_r == S_IDLE) && head_valid;
  assign dreq          = dreq_r;
  assign out_valid     = ov_r;
  assign out_r         = or_r;
  assign out_row_index = orow_r;
  assign out_last      = olast_r;
  assign out_status    = ost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tv_r         <= 1'b0;
      ov_r         <= 1'b0;
      dreq_r.start <= 1'b0;
    end else begin
      ov_r         <= 1'b0;
      dreq_r.start <= 1'b0;

      if (tv_r) begin
        acc_r <= sum;
        if (tlast_r) begin
          case (op_r)
            OP_MAT: begin
              if (col_r == 2'd2) begin
                ov_r    <= 1'b1;
                or_r    <= {32'd0, sres[31:0], res_r[1], res_r[0]};
                orow_r  <= row_r;
                olast_r <= (row_r == 2'd2);
                ost_r   <= (rflag_r || sres[32]) ? ST_SAT : ST_OK;
                col_r   <= 2'd0;
                row_r   <= row_r + 2'd1;
                rflag_r <= 1'b0;
              end else begin
                res_r[col_r] <= sres[31:0];
                rflag_r      <= rflag_r || sres[32];
                col_r        <= col_r + 2'd1;
              end
            end
            OP_MUL, OP_ROT: begin
              if ((op_r == OP_ROT) && !tgrp_r[2]) begin
                tq_r[tgrp_r[1:0]] <= sres[31:0];
              end else begin
                res_r[tgrp_r[1:0]] <= sres[31:0];
              end
              flag_r <= flag_r || sres[32];
              if (tfinal_r) begin
                ov_r    <= 1'b1;
                or_r    <= {(op_r == OP_MUL) ? sres[31:0] : 32'd0,
                            res_r[2], res_r[1], res_r[0]};
                orow_r  <= 2'd0;
                olast_r <= 1'b1;
                ost_r   <= (flag_r || sres[32]) ? ST_SAT : ST_OK;
              end
            end
            default: begin
              dreq_r.start   <= 1'b1;
              dreq_r.is_root <= 1'b1;
              dreq_r.num     <= sum[DIV_W-1:0];
              dreq_r.den     <= '0;
            end
          endcase
          if (tfinal_r) begin
            state_r <= ((op_r == OP_NORM) || (op_r == OP_INV)) ? S_ROOT : S_IDLE;
          end
        end
      end

      case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            op_r    <= head.op;
            a_r     <= head.a;
            b_r     <= head.b;
            bc_r    <= {head.b[3], bn2[31:0], bn1[31:0], bn0[31:0]};
            flag_r  <= (head.op == OP_ROT) && (bn0[32] || bn1[32] || bn2[32]);
            rflag_r <= 1'b0;
            col_r   <= 2'd0;
            row_r   <= 2'd0;
            iss_r   <= '0;
            len_r   <= prog_len(head.op);
            if (head.op == OP_CONJ) begin
              ov_r    <= 1'b1;
              or_r    <= {head.a[3], cj2[31:0], cj1[31:0], cj0[31:0]};
              orow_r  <= 2'd0;
              olast_r <= 1'b1;
              ost_r   <= (cj0[32] || cj1[32] || cj2[32]) ? ST_SAT : ST_OK;
            end else begin
              state_r <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (iss_r < len_r) begin
            prod_r   <= prod;
            tv_r     <= 1'b1;
            tneg_r   <= term.neg;
            traw_r   <= term.raw;
            tfirst_r <= (iss_r[1:0] == 2'd0);
            tlast_r  <= (iss_r[1:0] == 2'd3);
            tfinal_r <= (iss_r == len_r - 6'd1);
            tgrp_r   <= iss_r[5:2];
            iss_r    <= iss_r + 6'd1;
          end else begin
            tv_r <= 1'b0;
          end
        end
        S_ROOT: begin
          if (dresp.done) begin
            lval_r <= lnew;
            if (lnew == '0) begin
              ov_r    <= 1'b1;
              or_r    <= {(op_r == OP_NORM) ? Q_ONE : 32'd0, 32'd0, 32'd0, 32'd0};
              orow_r  <= 2'd0;
              olast_r <= 1'b1;
              ost_r   <= ST_ZERO;
              state_r <= S_IDLE;
            end else begin
              comp_r         <= 2'd0;
              pass_r         <= 1'b0;
              sgn_r          <= a_r[0][31];
              dreq_r.start   <= 1'b1;
              dreq_r.is_root <= 1'b0;
              dreq_r.num     <= num_of(a_r[0], lnew);
              dreq_r.den     <= lnew;
              state_r        <= S_DIV;
            end
          end
        end
        default: begin
          if (dresp.done) begin
            dreq_r.is_root <= 1'b0;
            dreq_r.den     <= lval_r;
            if ((op_r == OP_INV) && !pass_r) begin
              pass_r       <= 1'b1;
              dreq_r.start <= 1'b1;
              dreq_r.num   <= (dresp.res << FRAC_BITS) + DIV_W'(lval_r >> 1);
            end else begin
              res_r[comp_r] <= dres[31:0];
              flag_r        <= flag_r || dres[32];
              pass_r        <= 1'b0;
              if (comp_r == 2'd3) begin
                ov_r    <= 1'b1;
                or_r    <= {dres[31:0], res_r[2], res_r[1], res_r[0]};
                orow_r  <= 2'd0;
                olast_r <= 1'b1;
                ost_r   <= (flag_r || dres[32]) ? ST_SAT : ST_OK;
                state_r <= S_IDLE;
              end else begin
                comp_r       <= comp_r + 2'd1;
                sgn_r        <= a_r[comp_r + 2'd1][31];
                dreq_r.start <= 1'b1;
                dreq_r.num   <= num_of(a_r[comp_r + 2'd1], lval_r);
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- design/quaternion_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q16.16 quaternion product, conjugate, normalize, inverse, vector rotation
// and rotation matrix.
//
// A command transfers at a rising edge with start high and busy low. Busy
// rises only while the two-entry command queue is full; op codes six and
// seven are taken and dropped. Each result appears on the out_ ports for one
// cycle with out_valid high; the receiver takes it at that edge and cannot
// stall the block. The matrix op returns three rows, out_last on the third.
// The execution engine has a single 32x32 multiply-accumulate path and a
// one-bit-per-cycle divide and root unit. Conjugate needs neither; multiply,
// rotate and the matrix rows use the path; normalize takes 4 squares, 33 root
// steps and four 66-step divides, and inverse the same with eight divides.
// A zero length ends after the root. Each command is registered in the queue
// before the engine takes it. Commands queue while one executes.
// A synchronous reset empties the queue and idles the engine; nothing else
// holds state between commands.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_b_w,
  output logic        out_valid,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_r_w,
  output logic [1:0]  out_row_index,
  output logic        out_last,
  output logic [1:0]  out_status
);
  import qau_pkg::*;

  logic   head_valid;
  item_t  head;
  logic   pop;
  dreq_t  dreq;
  dresp_t dresp;
  quad_t  out_r;

  qau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_op      (in_op),
    .in_a       ({in_a_w, in_a_z, in_a_y, in_a_x}),
    .in_b       ({in_b_w, in_b_z, in_b_y, in_b_x}),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  qau_divroot u_divroot (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .resp  (dresp)
  );

  qau_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .dreq          (dreq),
    .dresp         (dresp),
    .out_valid     (out_valid),
    .out_r         (out_r),
    .out_row_index (out_row_index),
    .out_last      (out_last),
    .out_status    (out_status)
  );

  assign out_r_x = out_r[0];
  assign out_r_y = out_r[1];
  assign out_r_z = out_r[2];
  assign out_r_w = out_r[3];

endmodule

// ----- design/qau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks on the result channel of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
module qau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic signed [31:0] out_r_x,
  input logic signed [31:0] out_r_y,
  input logic signed [31:0] out_r_z,
  input logic signed [31:0] out_r_w,
  input logic [1:0]  out_row_index,
  input logic        out_last,
  input logic [1:0]  out_status
);
  import qau_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result strobe after reset.");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_index != 2'd3)
    else $error("Row index out of range.");

  a_row_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_r_w == 0 && out_status != ST_ZERO
                               && out_row_index != 2'd2)
    else $error("Intermediate matrix row malformed.");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |-> out_last && out_r_x == 0
                                          && out_r_y == 0 && out_r_z == 0)
    else $error("Zero-length result not cleared.");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_index != 2'd0 |-> out_r_w == 0)
    else $error("Matrix row carries a scalar part.");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);

// ----- tb/sv/quaternion_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// Drives commands for every op into the quaternion unit, predicts each result
// row in Q16.16 fixed point and compares every field of every output transfer.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;
  import qau_pkg::*;

  typedef logic signed [31:0] vec4_t [4];

  typedef struct {
    logic signed [31:0] r [4];
    logic [1:0]         row;
    logic               last;
    logic [1:0]         status;
  } qau_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_op;
  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_a_w;
  logic signed [31:0] in_b_x, in_b_y, in_b_z, in_b_w;
  logic out_valid;
  logic signed [31:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic [1:0] out_row_index;
  logic out_last;
  logic [1:0] out_status;

  qau_row_t pending_rows[$];
  int mismatches = 0;

  quaternion_arithmetic_unit dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat_q(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint p, longint q);
    return (p * q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic bit ham_product(longint p [4], longint q [4], output longint r [4]);
    longint t [4];
    bit f;
    f = 1'b0;
    t[0] = fx_mul(p[1], q[2]) - fx_mul(p[2], q[1]) + fx_mul(p[0], q[3]) + fx_mul(q[0], p[3]);
    t[1] = fx_mul(p[2], q[0]) - fx_mul(p[0], q[2]) + fx_mul(p[1], q[3]) + fx_mul(q[1], p[3]);
    t[2] = fx_mul(p[0], q[1]) - fx_mul(p[1], q[0]) + fx_mul(p[2], q[3]) + fx_mul(q[2], p[3]);
    t[3] = fx_mul(p[3], q[3]) - fx_mul(p[0], q[0]) - fx_mul(p[1], q[1]) - fx_mul(p[2], q[2]);
    for (int i = 0; i < 4; i++) r[i] = sat_q(t[i], f);
    return f;
  endfunction

  function automatic logic [63:0] quat_length(longint a [4]);
    logic [63:0] s, res, bitv;
    bit allmin;
    s = 0;
    allmin = 1'b1;
    for (int i = 0; i < 4; i++) begin
      s += a[i] * a[i];
      if (a[i] != -64'sd2147483648) allmin = 1'b0;
    end
    if (allmin) return 64'd1 << 32;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_round(longint v, logic [63:0] d);
    logic [63:0] mag, q;
    mag = (v < 0 ? -v : v);
    mag = mag << FRAC_BITS;
    q = (mag + d / 2) / d;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void push_row(longint v [4], int row, bit last, logic [1:0] status);
    qau_row_t e;
    for (int i = 0; i < 4; i++) e.r[i] = v[i][31:0];
    e.row = 2'(row);
    e.last = last;
    e.status = status;
    pending_rows.push_back(e);
  endfunction

  function automatic void predict_rows(logic [2:0] op, vec4_t av, vec4_t bv);
    longint a [4], b [4], r [4], v [4], bc [4], tmp [4], m [3][3], rw [4];
    logic [63:0] len;
    longint xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, t;
    bit f, rf;
    f = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = av[i];
      b[i] = bv[i];
      r[i] = 0;
    end
    case (op)
      OP_MUL: f = ham_product(a, b, r);
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) r[i] = sat_q(-a[i], f);
        r[3] = a[3];
      end
      OP_NORM, OP_INV: begin
        len = quat_length(a);
        if (len == 0) begin
          if (op == OP_NORM) r[3] = 64'sd1 <<< FRAC_BITS;
          push_row(r, 0, 1'b1, ST_ZERO);
          return;
        end
        for (int i = 0; i < 4; i++) begin
          t = div_round(a[i], len);
          if (op == OP_INV) begin
            t = div_round(t, len);
            if (i < 3) t = -t;
            t = sat_q(t, f);
          end
          r[i] = t;
        end
      end
      OP_ROT: begin
        v[0] = a[0];
        v[1] = a[1];
        v[2] = a[2];
        v[3] = 0;
        for (int i = 0; i < 3; i++) bc[i] = sat_q(-b[i], f);
        bc[3] = b[3];
        if (ham_product(b, v, tmp)) f = 1'b1;
        if (ham_product(tmp, bc, r)) f = 1'b1;
        r[3] = 0;
      end
      OP_MAT: begin
        xx = fx_mul(b[0], b[0]);
        yy = fx_mul(b[1], b[1]);
        zz = fx_mul(b[2], b[2]);
        ww = fx_mul(b[3], b[3]);
        xy = fx_mul(b[0], b[1]);
        xz = fx_mul(b[0], b[2]);
        yz = fx_mul(b[1], b[2]);
        wx = fx_mul(b[3], b[0]);
        wy = fx_mul(b[3], b[1]);
        wz = fx_mul(b[3], b[2]);
        m[0][0] = ww + xx - yy - zz;
        m[0][1] = 2 * (xy + wz);
        m[0][2] = 2 * (xz - wy);
        m[1][0] = 2 * (xy - wz);
        m[1][1] = ww - xx + yy - zz;
        m[1][2] = 2 * (yz + wx);
        m[2][0] = 2 * (xz + wy);
        m[2][1] = 2 * (yz - wx);
        m[2][2] = ww - xx - yy + zz;
        for (int k = 0; k < 3; k++) begin
          rf = 1'b0;
          for (int j = 0; j < 3; j++) rw[j] = sat_q(m[k][j], rf);
          rw[3] = 0;
          push_row(rw, k, k == 2, rf ? ST_SAT : ST_OK);
        end
        return;
      end
      default: return;
    endcase
    push_row(r, 0, 1'b1, f ? ST_SAT : ST_OK);
  endfunction

  // Drives one command and holds it until the transfer happens.
  task automatic send_cmd(logic [2:0] op, vec4_t a, vec4_t b, bit may_idle);
    bit taken;
    if (may_idle && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    {in_a_x, in_a_y, in_a_z, in_a_w} <= {a[0], a[1], a[2], a[3]};
    {in_b_x, in_b_y, in_b_z, in_b_w} <= {b[0], b[1], b[2], b[3]};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    predict_rows(op, a, b);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      8: begin
        case ($urandom_range(0, 4))
          0: return 32'sh80000000;
          1: return 32'sh7fffffff;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return ($signed($urandom_range(0, 4)) - 2) <<< FRAC_BITS;
    endcase
  endfunction

  function automatic void rand_quat(output vec4_t q);
    for (int i = 0; i < 4; i++) q[i] = rand_comp();
  endfunction

  task automatic test_each_op_extremes();
    vec4_t zero, maxv, minv, one, mixed;
    zero = '{0, 0, 0, 0};
    maxv = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    minv = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    one = '{0, 0, 0, 32'sh00010000};
    mixed = '{32'sh00018000, -32'sh00020000, 32'sh00004000, 32'sh00010000};
    for (int op = OP_MUL; op <= OP_MAT; op++) begin
      send_cmd(3'(op), maxv, minv, 1'b0);
      send_cmd(3'(op), mixed, one, 1'b0);
    end
    send_cmd(OP_MUL, minv, minv, 1'b0);
    send_cmd(OP_NORM, minv, zero, 1'b0);
    send_cmd(OP_INV, minv, zero, 1'b0);
    send_cmd(OP_MAT, zero, maxv, 1'b0);
    go_idle();
  endtask

  task automatic test_special_cases();
    vec4_t zero, conj_min, tiny, rot_min;
    zero = '{0, 0, 0, 0};
    conj_min = '{32'sh80000000, 5, 32'sh80000000, 32'sh80000000};
    tiny = '{1, 0, 0, 0};
    rot_min = '{32'sh80000000, 32'sh80000000, 0, 32'sh00010000};
    send_cmd(OP_NORM, zero, zero, 1'b0);
    send_cmd(OP_INV, zero, zero, 1'b0);
    send_cmd(OP_CONJ, conj_min, zero, 1'b0);
    send_cmd(3'd6, conj_min, conj_min, 1'b0);
    send_cmd(3'd7, tiny, tiny, 1'b0);
    send_cmd(OP_NORM, tiny, zero, 1'b0);
    send_cmd(OP_INV, tiny, zero, 1'b0);
    send_cmd(OP_ROT, tiny, rot_min, 1'b0);
    send_cmd(OP_ROT, rot_min, conj_min, 1'b0);
    go_idle();
  endtask

  task automatic run_random(int count, bit may_idle);
    vec4_t a, b;
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      rand_quat(a);
      rand_quat(b);
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 15) == 0) a = '{0, 0, 0, 0};
      send_cmd(op, a, b, may_idle);
    end
    go_idle();
  endtask

  task automatic test_random_with_gaps();
    run_random(380, 1'b1);
  endtask

  task automatic test_random_back_to_back();
    run_random(120, 1'b0);
  endtask

  always @(negedge clk) begin
    qau_row_t e;
    if (rst_n && out_valid) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: x=%h", out_r_x);
      end else begin
        e = pending_rows.pop_front();
        if (out_r_x !== e.r[0] || out_r_y !== e.r[1] || out_r_z !== e.r[2] ||
            out_r_w !== e.r[3] || out_row_index !== e.row || out_last !== e.last ||
            out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %h %h %h %h row %0d last %0d status %0d",
                     e.r[0], e.r[1], e.r[2], e.r[3], e.row, e.last, e.status);
            $display("          actual   %h %h %h %h row %0d last %0d status %0d",
                     out_r_x, out_r_y, out_r_z, out_r_w, out_row_index, out_last,
                     out_status);
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_MUL;
    {in_a_x, in_a_y, in_a_z, in_a_w} <= '0;
    {in_b_x, in_b_y, in_b_z, in_b_w} <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_each_op_extremes();
    test_special_cases();
    test_random_with_gaps();
    test_random_back_to_back();
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
